[rtl/pca_pkg.sv]
// Shared types and constants for the pixel color adjust block.
package pca_pkg;

   // Pixel words on the request and response channels
   typedef struct packed {
      logic [7:0] in_red;
      logic [7:0] in_green;
      logic [7:0] in_blue;
      logic [7:0] in_alpha;
   } pix_in_type;

   typedef struct packed {
      logic [7:0] out_red;
      logic [7:0] out_green;
      logic [7:0] out_blue;
      logic [7:0] out_alpha;
   } pix_out_type;

   // Operating modes
   typedef enum logic [2:0] {
      MODE_SATURATION = 3'd0,
      MODE_GAIN       = 3'd1,
      MODE_INVERT     = 3'd2,
      MODE_CONTRAST   = 3'd3,
      MODE_POSTERIZE  = 3'd4,
      MODE_THRESHOLD  = 3'd5
   } mode_type;

   // Register map
   typedef enum logic [2:0] {
      REG_MODE       = 3'd0,
      REG_GAIN_RED   = 3'd1,
      REG_GAIN_GREEN = 3'd2,
      REG_GAIN_BLUE  = 3'd3,
      REG_BRIGHTNESS = 3'd4,
      REG_CONTRAST   = 3'd5,
      REG_LEVELS     = 3'd6,
      REG_CUTOFF     = 3'd7
   } reg_index_type;

   localparam int CSR_DATA_W = 10;

   // Iterative divider sizing
   localparam int DIV_NUM_W = 27;
   localparam int DIV_DEN_W = 17;
   localparam int DIV_CNT_W = $clog2(DIV_NUM_W + 1);

   // Contrast factor (units of 1/256) and posterize reciprocal widths
   localparam int CON_F_W    = 16;
   localparam int POST_M_W   = 26;
   localparam int POST_SHIFT = 26;

   // ceil(2^26 / 510): exact floor division by 510 for values below 2^17
   localparam int RECIP_W    = 18;
   localparam logic [RECIP_W-1:0] POST_RECIP = RECIP_W'(131587);

   // Divider handshake toward the owner
   typedef struct packed {
      logic busy;
      logic done;
   } div_status_type;

endpackage

[rtl/pixel_color_adjust_core.sv]
// Pixel color adjust core: four-stage pipeline plus configuration registers.
//
// Point color adjustment of one RGBA pixel word per clock while req_ready is
// high. A word accepted on req_ passes the four register stages, each with a
// valid bit, and is presented on rsp_ from stage 4; bubbles are filled while
// the output is stalled. Writing the contrast or level count register starts
// a divide that forms the contrast factor or posterize reciprocal; req_ready
// is low after such a write until the divide is done. The user must write
// registers only while no word is in flight; the block itself does not
// enforce this.
module pixel_color_adjust_core import pca_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  pix_in_type            req_data,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output pix_out_type           rsp_data,
   input  logic                  csr_we,
   input  logic [2:0]            csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   // Round a value in units of 1/256 to a clamped byte
   function automatic logic [7:0] round_byte(input logic signed [25:0] v);
      logic signed [25:0] t;
      logic [7:0]         r;
      t = v + 26'sd128;
      if (t[25] || (t == '0)) r = 8'd0;
      else if (|t[24:16])     r = 8'd255;
      else                    r = t[15:8];
      return r;
   endfunction

   // ---------------------------------------------------------------
   // Configuration registers
   // ---------------------------------------------------------------
   mode_type           mode_ff, mode_in;
   logic [9:0]         gain_ff [0:2];
   logic [9:0]         gain_in [0:2];
   logic signed [8:0]  bright_ff, bright_in;
   logic signed [8:0]  con_c_ff, con_c_in;
   logic [7:0]         post_s_ff, post_s_in;
   logic [7:0]         cutoff_ff, cutoff_in;
   logic               con_load_ff, con_load_in;
   logic               post_load_ff, post_load_in;
   logic [CON_F_W-1:0] con_f_ff, con_f_in;
   logic [POST_M_W-1:0] post_m_ff, post_m_in;

   logic signed [8:0]  wr_s9;
   logic [8:0]         wr_n;

   always_comb begin
      mode_in      = mode_ff;
      gain_in      = gain_ff;
      bright_in    = bright_ff;
      con_c_in     = con_c_ff;
      post_s_in    = post_s_ff;
      cutoff_in    = cutoff_ff;
      con_load_in  = 1'b0;
      post_load_in = 1'b0;
      wr_s9        = $signed(csr_wdata[8:0]);
      wr_n         = csr_wdata[8:0];
      if (csr_we) begin
         unique case (reg_index_type'(csr_index))
            REG_MODE:       mode_in    = mode_type'(csr_wdata[2:0]);
            REG_GAIN_RED:   gain_in[0] = csr_wdata[9:0];
            REG_GAIN_GREEN: gain_in[1] = csr_wdata[9:0];
            REG_GAIN_BLUE:  gain_in[2] = csr_wdata[9:0];
            REG_BRIGHTNESS: bright_in  = wr_s9;
            REG_CONTRAST: begin
               // -256 acts as -255
               con_c_in    = (wr_s9 == -9'sd256) ? -9'sd255 : wr_s9;
               con_load_in = 1'b1;
            end
            REG_LEVELS: begin
               // Level count clamped to 2..256, stored as count minus one
               if (wr_n < 9'd2)        post_s_in = 8'd1;
               else if (wr_n > 9'd256) post_s_in = 8'd255;
               else                    post_s_in = 8'(wr_n - 9'd1);
               post_load_in = 1'b1;
            end
            REG_CUTOFF:     cutoff_in  = csr_wdata[7:0];
            default: ;
         endcase
      end
   end

   // ---------------------------------------------------------------
   // Factor dividers
   // ---------------------------------------------------------------
   div_status_type       con_st, post_st;
   logic [DIV_NUM_W-1:0] con_numer, con_quot, post_numer, post_quot;
   logic [DIV_DEN_W-1:0] con_denom, post_denom;
   logic signed [10:0]   con_u_s, con_w_s;
   logic [8:0]           con_u;
   logic [9:0]           con_w;
   logic [17:0]          con_u259;
   logic [17:0]          con_den18;
   logic [8:0]           post_d;
   logic                 cfg_busy;

   // Contrast: F = round(259*(c+255)*256 / (255*(259-c)))
   always_comb begin
      con_u_s   = 11'(con_c_ff) + 11'sd255;
      con_w_s   = 11'sd259 - 11'(con_c_ff);
      con_u     = con_u_s[8:0];
      con_w     = con_w_s[9:0];
      con_u259  = {9'b0, con_u} * 18'd259;
      con_den18 = {con_w, 8'b0} - {8'b0, con_w};
      con_denom = con_den18[DIV_DEN_W-1:0];
      con_numer = {1'b0, con_u259, 8'b0} + DIV_NUM_W'(con_denom >> 1);
   end

   // Posterize: M = ceil(2^26 / (2*s))
   assign post_d     = {post_s_ff, 1'b0};
   assign post_denom = DIV_DEN_W'(post_d);
   assign post_numer = (DIV_NUM_W'(1) << POST_SHIFT) + DIV_NUM_W'(post_d)
                       - DIV_NUM_W'(1);

   pca_divider u_con_div (
      .clock  (clock),
      .reset  (reset),
      .start  (con_load_ff),
      .numer  (con_numer),
      .denom  (con_denom),
      .status (con_st),
      .quot   (con_quot)
   );

   pca_divider u_post_div (
      .clock  (clock),
      .reset  (reset),
      .start  (post_load_ff),
      .numer  (post_numer),
      .denom  (post_denom),
      .status (post_st),
      .quot   (post_quot)
   );

   assign con_f_in  = con_st.done  ? con_quot[CON_F_W-1:0]   : con_f_ff;
   assign post_m_in = post_st.done ? post_quot[POST_M_W-1:0] : post_m_ff;
   assign cfg_busy  = con_load_ff | post_load_ff | con_st.busy | post_st.busy;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff      <= MODE_SATURATION;
         gain_ff[0]   <= 10'd256;
         gain_ff[1]   <= 10'd256;
         gain_ff[2]   <= 10'd256;
         bright_ff    <= '0;
         con_c_ff     <= '0;
         post_s_ff    <= 8'd1;
         cutoff_ff    <= 8'd128;
         con_load_ff  <= 1'b0;
         post_load_ff <= 1'b0;
         con_f_ff     <= CON_F_W'(256);
         post_m_ff    <= POST_M_W'(1) << (POST_SHIFT - 1);
      end else begin
         mode_ff      <= mode_in;
         gain_ff      <= gain_in;
         bright_ff    <= bright_in;
         con_c_ff     <= con_c_in;
         post_s_ff    <= post_s_in;
         cutoff_ff    <= cutoff_in;
         con_load_ff  <= con_load_in;
         post_load_ff <= post_load_in;
         con_f_ff     <= con_f_in;
         post_m_ff    <= post_m_in;
      end
   end

   // ---------------------------------------------------------------
   // Pipeline flow control
   // ---------------------------------------------------------------
   logic v1_ff, v2_ff, v3_ff, v4_ff;
   logic en1, en2, en3, en4;

   assign en4       = !v4_ff || rsp_ready;
   assign en3       = !v3_ff || en4;
   assign en2       = !v2_ff || en3;
   assign en1       = !v1_ff || en2;
   assign req_ready = en1 && !cfg_busy;
   assign rsp_valid = v4_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
      end else begin
         if (en1) v1_ff <= req_valid && req_ready;
         if (en2) v2_ff <= v1_ff;
         if (en3) v3_ff <= v2_ff;
         if (en4) v4_ff <= v3_ff;
      end
   end

   // ---------------------------------------------------------------
   // Stage 1: luma, brightness clamp, gain and posterize products
   // ---------------------------------------------------------------
   logic [7:0]  ch0 [0:2];
   logic [15:0] luma_sum;
   logic signed [9:0] bsum [0:2];

   logic [7:0]  ch1_ff [0:2];
   logic [7:0]  ch1_in [0:2];
   logic [7:0]  a1_ff;
   logic [7:0]  l1_ff, l1_in;
   logic [16:0] p1_ff [0:2];
   logic [16:0] p1_in [0:2];
   logic [7:0]  t1_ff [0:2];
   logic [7:0]  t1_in [0:2];
   logic [17:0] gp1_ff [0:2];
   logic [17:0] gp1_in [0:2];

   assign ch0[0] = req_data.in_red;
   assign ch0[1] = req_data.in_green;
   assign ch0[2] = req_data.in_blue;

   always_comb begin
      luma_sum = ({8'b0, ch0[0]} * 16'd77) + ({8'b0, ch0[1]} * 16'd150)
                 + ({8'b0, ch0[2]} * 16'd29);
      l1_in    = luma_sum[15:8];
      for (int i = 0; i < 3; i++) begin
         ch1_in[i] = ch0[i];
         p1_in[i]  = ({9'b0, ch0[i]} * {8'b0, post_d}) + 17'd255;
         gp1_in[i] = {10'b0, ch0[i]} * {8'b0, gain_ff[i]};
         bsum[i]   = $signed({2'b0, ch0[i]}) + 10'(bright_ff);
         if (bsum[i] < 0)               t1_in[i] = 8'd0;
         else if (bsum[i] > 10'sd255)   t1_in[i] = 8'd255;
         else                           t1_in[i] = bsum[i][7:0];
      end
   end

   always_ff @(posedge clock) begin
      if (en1) begin
         ch1_ff <= ch1_in;
         a1_ff  <= req_data.in_alpha;
         l1_ff  <= l1_in;
         p1_ff  <= p1_in;
         t1_ff  <= t1_in;
         gp1_ff <= gp1_in;
      end
   end

   // ---------------------------------------------------------------
   // Stage 2: saturation and contrast products, posterize level index
   // ---------------------------------------------------------------
   logic signed [8:0]  sdiff [0:2];
   logic signed [9:0]  tdiff [0:2];
   logic [34:0]        qprod [0:2];

   logic [7:0]         ch2_ff [0:2];
   logic [7:0]         a2_ff;
   logic [7:0]         l2_ff;
   logic               above2_ff, above2_in;
   logic signed [19:0] sp2_ff [0:2];
   logic signed [19:0] sp2_in [0:2];
   logic signed [25:0] cp2_ff [0:2];
   logic signed [25:0] cp2_in [0:2];
   logic [7:0]         q2_ff [0:2];
   logic [7:0]         q2_in [0:2];
   logic [17:0]        gp2_ff [0:2];

   always_comb begin
      above2_in = (l1_ff > cutoff_ff);
      for (int i = 0; i < 3; i++) begin
         sdiff[i]  = $signed({1'b0, ch1_ff[i]}) - $signed({1'b0, l1_ff});
         sp2_in[i] = sdiff[i] * $signed({1'b0, gain_ff[0]});
         tdiff[i]  = $signed({2'b0, t1_ff[i]}) - 10'sd128;
         cp2_in[i] = tdiff[i] * $signed({1'b0, con_f_ff});
         qprod[i]  = {18'b0, p1_ff[i]} * {17'b0, POST_RECIP};
         q2_in[i]  = qprod[i][POST_SHIFT+7:POST_SHIFT];
      end
   end

   always_ff @(posedge clock) begin
      if (en2) begin
         ch2_ff    <= ch1_ff;
         a2_ff     <= a1_ff;
         l2_ff     <= l1_ff;
         above2_ff <= above2_in;
         sp2_ff    <= sp2_in;
         cp2_ff    <= cp2_in;
         q2_ff     <= q2_in;
         gp2_ff    <= gp1_ff;
      end
   end

   // ---------------------------------------------------------------
   // Stage 3: rounding per mode, posterize reconstruction numerator
   // ---------------------------------------------------------------
   logic signed [25:0] vsat [0:2];

   logic [7:0]         res3_ff [0:2];
   logic [7:0]         res3_in [0:2];
   logic [16:0]        n3_ff [0:2];
   logic [16:0]        n3_in [0:2];
   logic [7:0]         a3_ff, a3_in;

   always_comb begin
      a3_in = (mode_ff == MODE_THRESHOLD) ? 8'd255 : a2_ff;
      for (int i = 0; i < 3; i++) begin
         vsat[i]  = $signed({10'b0, l2_ff, 8'b0}) + 26'(sp2_ff[i]);
         n3_in[i] = ({9'b0, q2_ff[i]} * 17'd510) + {9'b0, post_s_ff};
         unique case (mode_ff)
            MODE_SATURATION: res3_in[i] = round_byte(vsat[i]);
            MODE_GAIN:       res3_in[i] = round_byte($signed({8'b0, gp2_ff[i]}));
            MODE_INVERT:     res3_in[i] = ~ch2_ff[i];
            MODE_CONTRAST:   res3_in[i] = round_byte(cp2_ff[i] + 26'sd32768);
            MODE_THRESHOLD:  res3_in[i] = above2_ff ? 8'd255 : 8'd0;
            default:         res3_in[i] = ch2_ff[i];
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (en3) begin
         res3_ff <= res3_in;
         n3_ff   <= n3_in;
         a3_ff   <= a3_in;
      end
   end

   // ---------------------------------------------------------------
   // Stage 4: posterize reconstruction product, output word register
   // ---------------------------------------------------------------
   pix_out_type out4_ff, out4_in;
   logic        sel_post;
   logic [42:0] pprod [0:2];
   logic [7:0]  post4 [0:2];

   assign sel_post = (mode_ff == MODE_POSTERIZE);

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         pprod[i] = {26'b0, n3_ff[i]} * {17'b0, post_m_ff};
         post4[i] = pprod[i][POST_SHIFT+7:POST_SHIFT];
      end
      out4_in.out_red   = sel_post ? post4[0] : res3_ff[0];
      out4_in.out_green = sel_post ? post4[1] : res3_ff[1];
      out4_in.out_blue  = sel_post ? post4[2] : res3_ff[2];
      out4_in.out_alpha = a3_ff;
   end

   always_ff @(posedge clock) begin
      if (en4) out4_ff <= out4_in;
   end

   assign rsp_data = out4_ff;

endmodule

[rtl/pca_divider.sv]
// Restoring radix-2 divider, one quotient bit per cycle.
module pca_divider import pca_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   input  logic [DIV_NUM_W-1:0] numer,
   input  logic [DIV_DEN_W-1:0] denom,
   output div_status_type       status,
   output logic [DIV_NUM_W-1:0] quot
);

   logic [DIV_CNT_W-1:0] cnt_ff, cnt_in;
   logic [DIV_DEN_W-1:0] rem_ff, rem_in;
   logic [DIV_DEN_W-1:0] den_ff, den_in;
   logic [DIV_NUM_W-1:0] quo_ff, quo_in;
   logic                 done_ff, done_in;

   logic [DIV_DEN_W:0]   trial;
   logic [DIV_DEN_W:0]   diff;
   logic                 fits;

   // One shift-subtract step
   assign trial = {rem_ff, quo_ff[DIV_NUM_W-1]};
   assign diff  = trial - {1'b0, den_ff};
   assign fits  = (trial >= {1'b0, den_ff});

   always_comb begin
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      quo_in  = quo_ff;
      done_in = 1'b0;
      if (start) begin
         cnt_in = DIV_CNT_W'(DIV_NUM_W);
         rem_in = '0;
         den_in = denom;
         quo_in = numer;
      end else if (cnt_ff != '0) begin
         rem_in  = fits ? diff[DIV_DEN_W-1:0] : trial[DIV_DEN_W-1:0];
         quo_in  = {quo_ff[DIV_NUM_W-2:0], fits};
         cnt_in  = cnt_ff - 1'b1;
         done_in = (cnt_ff == DIV_CNT_W'(1));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff  <= '0;
         done_ff <= 1'b0;
      end else begin
         cnt_ff  <= cnt_in;
         done_ff <= done_in;
      end
      rem_ff <= rem_in;
      den_ff <= den_in;
      quo_ff <= quo_in;
   end

   assign status.busy = (cnt_ff != '0) || done_ff;
   assign status.done = done_ff;
   assign quot        = quo_ff;

endmodule
